// ===== design/pih_pkg.sv =====
// Shared types, codes and helpers for the point-in-figure hit test.
// No dependencies; used by point_in_figure_hit_test.
package pih_pkg;

  localparam int MAX_FIGURES_DEF = 16;
  localparam int COORD_W         = 24;
  localparam int COORDS          = 6;
  localparam int KIND_W          = 2;
  localparam int ROW_W           = KIND_W + COORDS * COORD_W;
  localparam int DIFF_W          = COORD_W + 1;
  localparam int PROD_W          = 2 * DIFF_W;
  localparam int ACC_W           = PROD_W + 2;
  localparam int PNUM_W          = 16;
  localparam int FNUM_W          = 5;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_RECT   = 2'd0,
    KIND_CIRCLE = 2'd1,
    KIND_TRI    = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_HIT    = 2'd0,
    STATUS_NONE   = 2'd1,
    STATUS_REJECT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FINISH,
    ST_REJECT
  } state_t;

  // Step on which each kind reaches its decision.
  localparam logic [3:0] RECT_DECIDE   = 4'd0;
  localparam logic [3:0] CIRCLE_DECIDE = 4'd4;
  localparam logic [3:0] TRI_DECIDE    = 4'd9;

  // Exact difference of two coordinates, one bit wider.
  function automatic logic signed [DIFF_W-1:0] sdiff(input logic [COORD_W-1:0] p,
                                                     input logic [COORD_W-1:0] q);
    sdiff = $signed({p[COORD_W-1], p}) - $signed({q[COORD_W-1], q});
  endfunction

endpackage

// ===== design/point_in_figure_hit_test.sv =====
// Top level of the point-in-figure hit test: sequencer, shared multiplier, result register.
// Depends on pih_pkg and pih_ram.

// Keeps a table of up to MAX_FIGURES figures (rectangle, circle or triangle) and tests
// query points against them in load order. One item on the input stream is a load, a
// query or a clear (selected by s_tuser). Loads and clears give no result, except a
// load into a full table, which gives one status-2 result. A query gives one result
// per containing figure, the final one flagged by m_tlast, or a single "none" result.
// Rectangles and circles are strict, triangle edges count as inside and a degenerate
// triangle never matches. For each stored figure a query reads its RAM entry and then
// evaluates it, circles and triangles on the one shared 25x25 multiplier, before the
// final result; a stall on the result side holds it. s_tready is low for the whole
// query. The table RAM needs no clearing: only loaded entries are ever read.
module point_in_figure_hit_test #(
  parameter int MAX_FIGURES = pih_pkg::MAX_FIGURES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [143:0]  s_tdata,   // coord_a[23:0], coord_b, coord_c, coord_d, coord_e, coord_f
  input  logic [3:0]    s_tuser,   // operation[1:0], figure_kind[3:2]
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [23:0]   m_tdata,   // point_number[15:0], figure_number[20:16], zeros[23:21]
  output logic [1:0]    m_tuser,   // status[1:0]
  output logic          m_tlast    // last_result
);

  localparam int IW = MAX_FIGURES > 1 ? $clog2(MAX_FIGURES) : 1;
  localparam int CW = $clog2(MAX_FIGURES + 1);
  localparam int CWX = CW > pih_pkg::FNUM_W ? CW : pih_pkg::FNUM_W;
  localparam int CW_ = pih_pkg::COORD_W;

  pih_pkg::state_t state, state_next;

  logic [CW-1:0]               count;
  logic [IW-1:0]               idx;
  logic [3:0]                  step;
  logic [pih_pkg::PNUM_W-1:0]  pnum;
  logic [CW_-1:0]              qx, qy;
  logic                        pend_valid;
  logic [IW-1:0]               pend_idx;

  logic signed [pih_pkg::DIFF_W-1:0] mul_a, mul_b;
  logic signed [pih_pkg::PROD_W-1:0] prod;
  logic signed [pih_pkg::ACC_W-1:0]  r_a, r_b, r_d, r_c;

  logic [pih_pkg::ROW_W-1:0] rdata;
  logic                      accept, slot_free, decide, hit, last_fig, emit_mid;
  pih_pkg::op_t              op;
  pih_pkg::kind_t            kind;
  logic [CW_-1:0]            f0, f1, f2, f3, f4, f5;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == pih_pkg::ST_IDLE);
  assign slot_free = !m_tvalid || m_tready;
  assign op        = pih_pkg::op_t'(s_tuser[1:0]);

  // Figure table: kind on top, six coordinates below.
  pih_ram #(
    .WIDTH(pih_pkg::ROW_W),
    .DEPTH(MAX_FIGURES)
  ) u_table (
    .clk  (clk),
    .we   (accept && op == pih_pkg::OP_LOAD && count < CW'(MAX_FIGURES)),
    .waddr(count[IW-1:0]),
    .wdata({s_tuser[3:2], s_tdata}),
    .raddr(idx),
    .rdata(rdata)
  );

  assign kind = pih_pkg::kind_t'(rdata[pih_pkg::ROW_W-1 -: pih_pkg::KIND_W]);
  assign f0 = rdata[0*CW_ +: CW_];
  assign f1 = rdata[1*CW_ +: CW_];
  assign f2 = rdata[2*CW_ +: CW_];
  assign f3 = rdata[3*CW_ +: CW_];
  assign f4 = rdata[4*CW_ +: CW_];
  assign f5 = rdata[5*CW_ +: CW_];

  assign last_fig = (CW'(idx) + CW'(1) == count);

  // Operand select and decision for the current figure step.
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    decide = 1'b0;
    hit    = 1'b0;
    case (kind)
      pih_pkg::KIND_RECT: begin
        decide = (step == pih_pkg::RECT_DECIDE);
        hit = ($signed(qx) > $signed(f0)) && ($signed(qx) < $signed(f2)) &&
              ($signed(qy) < $signed(f1)) && ($signed(qy) > $signed(f3));
      end
      pih_pkg::KIND_CIRCLE: begin
        case (step)
          4'd0: begin
            mul_a = pih_pkg::sdiff(qx, f0);
            mul_b = pih_pkg::sdiff(qx, f0);
          end
          4'd1: begin
            mul_a = pih_pkg::sdiff(qy, f1);
            mul_b = pih_pkg::sdiff(qy, f1);
          end
          4'd2: begin
            mul_a = pih_pkg::sdiff(f2, '0);
            mul_b = pih_pkg::sdiff(f2, '0);
          end
          default: ;
        endcase
        decide = (step == pih_pkg::CIRCLE_DECIDE);
        hit    = (r_a < r_d);
      end
      pih_pkg::KIND_TRI: begin
        case (step)
          4'd0: begin
            mul_a = pih_pkg::sdiff(f3, f5);
            mul_b = pih_pkg::sdiff(f0, f4);
          end
          4'd1: begin
            mul_a = pih_pkg::sdiff(f4, f2);
            mul_b = pih_pkg::sdiff(f1, f5);
          end
          4'd2: begin
            mul_a = pih_pkg::sdiff(f3, f5);
            mul_b = pih_pkg::sdiff(qx, f4);
          end
          4'd3: begin
            mul_a = pih_pkg::sdiff(f4, f2);
            mul_b = pih_pkg::sdiff(qy, f5);
          end
          4'd4: begin
            mul_a = pih_pkg::sdiff(f5, f1);
            mul_b = pih_pkg::sdiff(qx, f4);
          end
          4'd5: begin
            mul_a = pih_pkg::sdiff(f0, f4);
            mul_b = pih_pkg::sdiff(qy, f5);
          end
          default: ;
        endcase
        decide = (step == pih_pkg::TRI_DECIDE);
        // r_d = det, r_a/r_b/r_c = barycentric numerators
        hit = ((r_d > 0) && (r_a >= 0) && (r_b >= 0) && (r_c >= 0)) ||
              ((r_d < 0) && (r_a <= 0) && (r_b <= 0) && (r_c <= 0));
      end
      default: begin
        decide = 1'b1;
        hit    = 1'b0;
      end
    endcase
  end

  assign emit_mid = (state == pih_pkg::ST_EVAL) && decide && hit && pend_valid && slot_free;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      pih_pkg::ST_IDLE: begin
        if (accept) begin
          case (op)
            pih_pkg::OP_LOAD:
              if (count >= CW'(MAX_FIGURES)) state_next = pih_pkg::ST_REJECT;
            pih_pkg::OP_QUERY:
              state_next = (count == '0) ? pih_pkg::ST_FINISH : pih_pkg::ST_READ;
            default: ;
          endcase
        end
      end
      pih_pkg::ST_READ: state_next = pih_pkg::ST_EVAL;
      pih_pkg::ST_EVAL: begin
        if (decide && !(hit && pend_valid && !slot_free)) begin
          state_next = last_fig ? pih_pkg::ST_FINISH : pih_pkg::ST_READ;
        end
      end
      pih_pkg::ST_FINISH, pih_pkg::ST_REJECT: begin
        if (slot_free) state_next = pih_pkg::ST_IDLE;
      end
      default: state_next = pih_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pih_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control counters and pending hit.
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      pnum       <= '0;
      idx        <= '0;
      step       <= '0;
      pend_valid <= 1'b0;
    end else begin
      case (state)
        pih_pkg::ST_IDLE: begin
          idx        <= '0;
          step       <= '0;
          pend_valid <= 1'b0;
          if (accept) begin
            case (op)
              pih_pkg::OP_LOAD:
                if (count < CW'(MAX_FIGURES)) count <= count + CW'(1);
              pih_pkg::OP_QUERY: pnum <= pnum + 1'b1;
              pih_pkg::OP_CLEAR: begin
                count <= '0;
                pnum  <= '0;
              end
              default: ;
            endcase
          end
        end
        pih_pkg::ST_READ: step <= '0;
        pih_pkg::ST_EVAL: begin
          if (!decide) begin
            step <= step + 4'd1;
          end else if (!(hit && pend_valid && !slot_free)) begin
            if (hit) begin
              pend_valid <= 1'b1;
              pend_idx   <= idx;
            end
            if (!last_fig) idx <= IW'(idx + 1'b1);
          end
        end
        pih_pkg::ST_FINISH: if (slot_free) pend_valid <= 1'b0;
        default: ;
      endcase
    end
  end

  // Query point capture, shared multiplier and accumulators.
  always_ff @(posedge clk) begin
    if (accept && op == pih_pkg::OP_QUERY) begin
      qx <= s_tdata[0 +: CW_];
      qy <= s_tdata[CW_ +: CW_];
    end
    prod <= mul_a * mul_b;
    if (state == pih_pkg::ST_EVAL) begin
      case (kind)
        pih_pkg::KIND_CIRCLE:
          case (step)
            4'd1: r_a <= pih_pkg::ACC_W'(prod);
            4'd2: r_a <= r_a + pih_pkg::ACC_W'(prod);
            4'd3: r_d <= pih_pkg::ACC_W'(prod);
            default: ;
          endcase
        pih_pkg::KIND_TRI:
          case (step)
            4'd1: r_d <= pih_pkg::ACC_W'(prod);
            4'd2: r_d <= r_d + pih_pkg::ACC_W'(prod);
            4'd3: r_a <= pih_pkg::ACC_W'(prod);
            4'd4: r_a <= r_a + pih_pkg::ACC_W'(prod);
            4'd5: r_b <= pih_pkg::ACC_W'(prod);
            4'd6: r_b <= r_b + pih_pkg::ACC_W'(prod);
            4'd7: r_c <= r_d - r_a;
            4'd8: r_c <= r_c - r_b;
            default: ;
          endcase
        default: ;
      endcase
    end
  end

  // Result register.
  logic [CWX-1:0] fnum_full;
  assign fnum_full = CWX'(pend_idx) + CWX'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (emit_mid ||
          (state == pih_pkg::ST_FINISH && slot_free) ||
          (state == pih_pkg::ST_REJECT && slot_free)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (emit_mid) begin
      m_tuser <= pih_pkg::STATUS_HIT;
      m_tdata <= {3'b000, fnum_full[pih_pkg::FNUM_W-1:0], pnum};
      m_tlast <= 1'b0;
    end else if (state == pih_pkg::ST_FINISH && slot_free) begin
      m_tuser <= pend_valid ? pih_pkg::STATUS_HIT : pih_pkg::STATUS_NONE;
      m_tdata <= {3'b000, pend_valid ? fnum_full[pih_pkg::FNUM_W-1:0] : 5'd0, pnum};
      m_tlast <= 1'b1;
    end else if (state == pih_pkg::ST_REJECT && slot_free) begin
      m_tuser <= pih_pkg::STATUS_REJECT;
      m_tdata <= '0;
      m_tlast <= 1'b1;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_FIGURES))
    else $error("figure count beyond table size");

  a_eval_idx: assert property (@(posedge clk) disable iff (rst)
    (state == pih_pkg::ST_EVAL) |-> (CW'(idx) < count))
    else $error("evaluating an unloaded figure");

  a_none_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == pih_pkg::STATUS_NONE) |-> (m_tlast && m_tdata[20:16] == 5'd0))
    else $error("none result not final or carries a figure");

  a_reject_form: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == pih_pkg::STATUS_REJECT) |-> (m_tlast && m_tdata == '0))
    else $error("reject result malformed");

  a_mid_not_last: assert property (@(posedge clk) disable iff (rst)
    emit_mid |=> (m_tvalid && !m_tlast && m_tuser == pih_pkg::STATUS_HIT))
    else $error("intermediate hit lost or flagged last");

endmodule

// ===== design/pih_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the figure table of point_in_figure_hit_test.
module pih_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
